/* src/uer_pkg.sv */
// Package for the ultrasonic echo ranger: item types, register indexes and constants.
// Used by uer_cfg, uer_seq and the top level; depends on nothing.

package uer_pkg;

  localparam int CAPTURE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_TICK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_PERIOD = 1'd1;

  localparam logic [15:0] US_PER_TICK_RST = 16'd4096;
  localparam logic [15:0] TRIG_PERIOD_RST = 16'd700;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  localparam logic [15:0] US_MAX = 16'hFFFF;
  localparam int SOUND_CM_PER_MS = 33;

  // floor(x / 125) == (x * RECIP_Q4) >> RECIP_SHIFT for every x below 2^22.
  localparam int MUL_B_W = 23;
  localparam logic [MUL_B_W-1:0] RECIP_Q4 = 23'd4294968;
  localparam int RECIP_SHIFT = 29;
  localparam int SCALED_W = 22;

  typedef struct packed {
    logic        kind;
    logic [15:0] capture_ticks;
  } in_item_t;

  typedef struct packed {
    logic        trigger_out;
    logic        measurement_done;
    logic [15:0] echo_ticks;
    logic [15:0] pulse_us;
    logic [14:0] distance_q4;
  } out_item_t;

  typedef struct packed {
    logic [15:0] us_per_tick_q8;
    logic [15:0] trigger_period;
  } cfg_regs_t;

endpackage

/* src/uer_cfg.sv */
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for the register indexes and reset values.

module uer_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data,
  output uer_pkg::cfg_regs_t             regs
);

  uer_pkg::cfg_regs_t regs_r;
  uer_pkg::cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        uer_pkg::CFG_US_PER_TICK: regs_nxt.us_per_tick_q8 = cfg_data;
        uer_pkg::CFG_TRIG_PERIOD: regs_nxt.trigger_period = cfg_data;
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.us_per_tick_q8 <= uer_pkg::US_PER_TICK_RST;
      regs_r.trigger_period <= uer_pkg::TRIG_PERIOD_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

/* src/uer_mul.sv */
// Shared registered multiplier of the ultrasonic echo ranger.
// Standalone; the sequencer selects its operands.

module uer_mul #(
  parameter int AW = 22,
  parameter int BW = 23
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod
);

  logic [AW+BW-1:0] prod_r;

  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

endmodule

/* src/uer_seq.sv */
// Sequencer of the ultrasonic echo ranger: trigger counter, echo edge tracking,
// result register and operand control of the shared multiplier. Depends on uer_pkg.

module uer_seq #(
  parameter int CAPTURE_WIDTH = uer_pkg::CAPTURE_WIDTH_DEF,
  parameter int AW = 22,
  parameter int PW = 45
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  uer_pkg::cfg_regs_t       regs,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  uer_pkg::in_item_t        in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output uer_pkg::out_item_t       out_item,
  output logic                     mul_en,
  output logic [AW-1:0]            mul_a,
  output logic [uer_pkg::MUL_B_W-1:0] mul_b,
  input  logic [PW-1:0]            mul_prod
);

  localparam int CW = CAPTURE_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_QNT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [15:0]        tick_cnt_r, tick_cnt_nxt;
  logic               trig_r, trig_nxt;
  logic               expect_fall_r, expect_fall_nxt;
  logic [CW-1:0]      start_cap_r, start_cap_nxt;
  logic [15:0]        last_ticks_r, last_ticks_nxt;
  logic [14:0]        last_dist_r, last_dist_nxt;
  logic               done_r, done_nxt;
  logic [AW-1:0]      opa_r, opa_nxt;
  logic [15:0]        us_r, us_nxt;
  logic               out_valid_r, out_valid_nxt;
  uer_pkg::out_item_t out_item_r, out_item_nxt;

  logic [15:0]        cnt_inc;
  logic [CW-1:0]      cap_cw;
  logic [CW-1:0]      width_cw;
  logic [31:0]        width_32;
  logic [15:0]        us_sat;
  logic [uer_pkg::SCALED_W-1:0] scaled;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cnt_inc  = tick_cnt_r + 16'd1;
  assign cap_cw   = CW'(in_item.capture_ticks);
  assign width_cw = cap_cw - start_cap_r;
  assign width_32 = 32'(width_cw);
  assign us_sat   = (|mul_prod[PW-1:24]) ? uer_pkg::US_MAX : mul_prod[23:8];
  assign scaled   = uer_pkg::SCALED_W'(us_sat) *
                    uer_pkg::SCALED_W'(uer_pkg::SOUND_CM_PER_MS);

  assign mul_en = (state_r == S_MUL) || (state_r == S_DIV);
  assign mul_a  = opa_r;
  assign mul_b  = (state_r == S_DIV) ? uer_pkg::RECIP_Q4
                                     : uer_pkg::MUL_B_W'(regs.us_per_tick_q8);

  always_comb begin
    state_nxt       = state_r;
    tick_cnt_nxt    = tick_cnt_r;
    trig_nxt        = trig_r;
    expect_fall_nxt = expect_fall_r;
    start_cap_nxt   = start_cap_r;
    last_ticks_nxt  = last_ticks_r;
    last_dist_nxt   = last_dist_r;
    done_nxt        = done_r;
    opa_nxt         = opa_r;
    us_nxt          = us_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_item_nxt    = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          done_nxt  = 1'b0;
          opa_nxt   = AW'(last_ticks_r);
          state_nxt = S_MUL;
          if (in_item.kind == uer_pkg::KIND_TICK) begin
            if (cnt_inc == 16'd1) begin
              trig_nxt = 1'b1;
            end
            if (cnt_inc == 16'd2) begin
              trig_nxt = 1'b0;
            end
            tick_cnt_nxt = (cnt_inc >= regs.trigger_period) ? 16'd0 : cnt_inc;
          end else if (!expect_fall_r) begin
            start_cap_nxt   = cap_cw;
            expect_fall_nxt = 1'b1;
          end else begin
            expect_fall_nxt = 1'b0;
            done_nxt        = 1'b1;
            opa_nxt         = AW'(width_cw);
            last_ticks_nxt  = (|width_32[31:16]) ? uer_pkg::US_MAX : width_32[15:0];
          end
        end
      end
      S_MUL: begin
        state_nxt = S_SAT;
      end
      S_SAT: begin
        us_nxt = us_sat;
        if (done_r) begin
          opa_nxt   = AW'(scaled);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        state_nxt = S_QNT;
      end
      S_QNT: begin
        last_dist_nxt = mul_prod[uer_pkg::RECIP_SHIFT +: 15];
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_item_nxt.trigger_out      = trig_r;
          out_item_nxt.measurement_done = done_r;
          out_item_nxt.echo_ticks       = last_ticks_r;
          out_item_nxt.pulse_us         = us_r;
          out_item_nxt.distance_q4      = last_dist_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tick_cnt_r    <= 16'd0;
      trig_r        <= 1'b0;
      expect_fall_r <= 1'b0;
      start_cap_r   <= '0;
      last_ticks_r  <= 16'd0;
      last_dist_r   <= 15'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      trig_r        <= trig_nxt;
      expect_fall_r <= expect_fall_nxt;
      start_cap_r   <= start_cap_nxt;
      last_ticks_r  <= last_ticks_nxt;
      last_dist_r   <= last_dist_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_r     <= done_nxt;
    opa_r      <= opa_nxt;
    us_r       <= us_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

/* src/ultrasonic_echo_ranger_unit.sv */
// Ultrasonic echo ranger, top level: configuration registers, sequencer and multiplier.
// Depends on uer_pkg, uer_cfg, uer_mul and uer_seq.
//
// Each input item is a base timer tick or an echo edge capture, and each gives one
// result item. Ticks run the trigger counter; a falling echo edge measures the pulse
// width and converts it to microseconds and to distance in sixteenths of a centimeter.
// One multiplier is shared: it scales the width to microseconds and then divides the
// scaled value by 125 through a reciprocal product. A tick or rising edge passes through
// S_MUL, S_SAT and S_OUT to the result register and a falling edge through S_MUL, S_SAT,
// S_DIV, S_QNT and S_OUT, for its one or two passes through the multiplier. The input
// is stalled while an item is in work; a result waiting in the output register holds
// the next result back but not the next acceptance.

module ultrasonic_echo_ranger_unit #(
  parameter int CAPTURE_WIDTH = uer_pkg::CAPTURE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  uer_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output uer_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int AW = (CAPTURE_WIDTH > uer_pkg::SCALED_W) ? CAPTURE_WIDTH
                                                            : uer_pkg::SCALED_W;
  localparam int PW = AW + uer_pkg::MUL_B_W;

  uer_pkg::cfg_regs_t             regs;
  logic                           mul_en;
  logic [AW-1:0]                  mul_a;
  logic [uer_pkg::MUL_B_W-1:0]    mul_b;
  logic [PW-1:0]                  mul_prod;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  uer_mul #(
    .AW (AW),
    .BW (uer_pkg::MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  uer_seq #(
    .CAPTURE_WIDTH (CAPTURE_WIDTH),
    .AW            (AW),
    .PW            (PW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .mul_en    (mul_en),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_prod  (mul_prod)
  );

endmodule

/* test/tb.sv */
// Testbench for ultrasonic_echo_ranger_unit: checks trigger timing and echo width,
// microsecond and distance results against an in-bench predictor under random idling.
// Depends on uer_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module tb;
  import uer_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // Predictor state and register copies.
  logic [15:0] us_scale_q8;
  logic [15:0] period_reg;
  logic [15:0] base_count;
  logic        trig_level;
  logic        await_fall;
  logic [15:0] rise_capture;
  logic [15:0] held_width;
  logic [14:0] held_distance;

  out_item_t   pending_ranges[$];
  out_item_t   oldest;
  int          errors = 0;
  int          items_sent = 0;
  int          ranges_seen = 0;
  int          reg_writes = 0;
  bit          hold_out = 0;
  bit          calm_out = 0;
  bit          calm_in = 0;

  ultrasonic_echo_ranger_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] width_to_us(input logic [15:0] width);
    logic [31:0] scaled;
    scaled = (32'(width) * 32'(us_scale_q8)) >> 8;
    return (scaled > 32'(US_MAX)) ? US_MAX : scaled[15:0];
  endfunction

  function automatic out_item_t predict_range(input in_item_t it);
    out_item_t   res;
    logic [15:0] width;
    logic [31:0] range_full;
    res.measurement_done = 1'b0;
    if (it.kind == KIND_TICK) begin
      base_count = base_count + 16'd1;
      if (base_count == 16'd1) trig_level = 1'b1;
      if (base_count == 16'd2) trig_level = 1'b0;
      if (base_count >= period_reg) base_count = '0;
    end else if (!await_fall) begin
      rise_capture = it.capture_ticks;
      await_fall = 1'b1;
    end else begin
      width = it.capture_ticks - rise_capture;
      await_fall = 1'b0;
      held_width = width;
      range_full = (32'(width_to_us(width)) * 32'(SOUND_CM_PER_MS)) / 32'd125;
      held_distance = range_full[14:0];
      res.measurement_done = 1'b1;
    end
    res.trigger_out = trig_level;
    res.echo_ticks = held_width;
    res.pulse_us = width_to_us(held_width);
    res.distance_q4 = held_distance;
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic kind, input logic [15:0] cap, input bit paced);
    in_item_t it;
    int gap;
    it.kind = kind;
    it.capture_ticks = cap;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_ranges.push_back(predict_range(it));
    items_sent++;
    gap = (!paced || calm_in || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_US_PER_TICK) us_scale_q8 = val;
    else period_reg = val;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] us_q8, input logic [15:0] period);
    drain();
    write_reg(CFG_US_PER_TICK, us_q8);
    write_reg(CFG_TRIG_PERIOD, period);
  endtask

  task automatic measure(input logic [15:0] rise, input logic [15:0] fall);
    send_item(KIND_EDGE, rise, 1'b1);
    send_item(KIND_EDGE, fall, 1'b1);
  endtask

  task automatic test_reset_defaults();
    repeat (3) send_item(KIND_TICK, 16'hFFFF, 1'b1);
    measure(16'h0000, 16'h0000);
    measure(16'hFFFF, 16'h0000);
    measure(16'h0000, 16'hFFFF);
    send_item(KIND_TICK, 16'h0000, 1'b1);
  endtask

  task automatic test_register_extremes();
    configure(16'd0, 16'd1);
    repeat (2) send_item(KIND_TICK, 16'h5555, 1'b1);
    measure(16'd100, 16'd5100);
    configure(16'd65535, 16'd2);
    repeat (3) send_item(KIND_TICK, 16'hAAAA, 1'b1);
    measure(16'd0, 16'd1);
    configure(16'd1, 16'd0);
    repeat (2) send_item(KIND_TICK, 16'd0, 1'b1);
    measure(16'h8000, 16'h7FFF);
    configure(16'd256, 16'd65535);
    send_item(KIND_TICK, 16'd0, 1'b1);
    measure(16'd10, 16'd10);
  endtask

  task automatic test_random_traffic();
    logic [15:0] us_q8;
    logic [15:0] period;
    logic [15:0] cap;
    logic        kind;
    for (int phase = 0; phase < 11; phase++) begin
      case ($urandom_range(0, 5))
        0: us_q8 = 16'd1;
        1: us_q8 = 16'd65535;
        2: us_q8 = US_PER_TICK_RST;
        default: us_q8 = 16'($urandom_range(1, 8192));
      endcase
      case ($urandom_range(0, 5))
        0: period = 16'd3;
        1: period = 16'd65535;
        2: period = TRIG_PERIOD_RST;
        default: period = 16'($urandom_range(3, 12));
      endcase
      configure(us_q8, period);
      for (int n = 0; n < 150; n++) begin
        if (n % 50 == 0) calm_in = ($urandom_range(0, 3) == 0);
        kind = ($urandom_range(0, 1) == 0) ? KIND_TICK : KIND_EDGE;
        if (kind == KIND_TICK || !await_fall) begin
          cap = 16'($urandom_range(0, 65535));
        end else begin
          case ($urandom_range(0, 9))
            0: cap = 16'($urandom_range(0, 65535));
            1: cap = rise_capture - 16'($urandom_range(0, 50));
            2: cap = rise_capture + 16'($urandom_range(4000, 65535));
            default: cap = rise_capture + 16'($urandom_range(0, 4000));
          endcase
        end
        send_item(kind, cap, 1'b1);
      end
    end
    calm_in = 0;
  endtask

  task automatic test_output_backpressure();
    drain();
    hold_out = 1;
    for (int n = 0; n < 30; n++)
      send_item(($urandom_range(0, 1) == 0) ? KIND_TICK : KIND_EDGE,
                16'($urandom_range(0, 65535)), 1'b0);
    drain();
    for (int n = 0; n < 20; n++)
      send_item(($urandom_range(0, 2) == 0) ? KIND_TICK : KIND_EDGE,
                16'($urandom_range(0, 3000)), 1'b1);
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
        out_stall <= !calm_out && ($urandom_range(0, 2) == 0);
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        $error("result item with no pending input item");
        errors++;
      end else begin
        oldest = pending_ranges.pop_front();
        if (out_item.trigger_out !== oldest.trigger_out) begin
          $error("trigger_out: expected %0d, got %0d", oldest.trigger_out, out_item.trigger_out);
          errors++;
        end
        if (out_item.measurement_done !== oldest.measurement_done) begin
          $error("measurement_done: expected %0d, got %0d",
                 oldest.measurement_done, out_item.measurement_done);
          errors++;
        end
        if (out_item.echo_ticks !== oldest.echo_ticks) begin
          $error("echo_ticks: expected %0d, got %0d", oldest.echo_ticks, out_item.echo_ticks);
          errors++;
        end
        if (out_item.pulse_us !== oldest.pulse_us) begin
          $error("pulse_us: expected %0d, got %0d", oldest.pulse_us, out_item.pulse_us);
          errors++;
        end
        if (out_item.distance_q4 !== oldest.distance_q4) begin
          $error("distance_q4: expected %0d, got %0d", oldest.distance_q4, out_item.distance_q4);
          errors++;
        end
        if (oldest.measurement_done) ranges_seen++;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_US_PER_TICK;
    cfg_data <= '0;
    us_scale_q8 = US_PER_TICK_RST;
    period_reg = TRIG_PERIOD_RST;
    base_count = '0;
    trig_level = 1'b0;
    await_fall = 1'b0;
    rise_capture = '0;
    held_width = '0;
    held_distance = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    drain();

    if (pending_ranges.size() != 0) begin
      $error("%0d expected result items never arrived", pending_ranges.size());
      errors++;
    end
    $display("Sent %0d items (ticks and echo edges), %0d completed range measurements,",
             items_sent, ranges_seen);
    $display("%0d register writes across period and scale extremes, %0d mismatches.",
             reg_writes, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
